// File: rtl/lld_pkg.sv
`timescale 1ns / 1ps

package lld_pkg;

  // Field widths fixed by the item format
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned LIM_W      = 11;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned WID_W      = 11;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LINE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINE_WIDTH   = 2'd2;

  // Register reset values
  localparam logic [PIX_W-1:0] BRIGHT_THRESHOLD_RST = 8'd100;
  localparam logic [LIM_W-1:0] MIN_LINE_WIDTH_RST   = 11'd2;
  localparam logic [LIM_W-1:0] MAX_LINE_WIDTH_RST   = 11'd24;

  // Saturation bound of the steering sum
  localparam logic signed [SUM_W-1:0] STEER_LIMIT = 32'sd1073741824;

  typedef struct packed {
    logic [PIX_W-1:0] bright_threshold;
    logic [LIM_W-1:0] min_line_width;
    logic [LIM_W-1:0] max_line_width;
  } cfg_t;

  // Row result as seen on the output, less the steering sum
  typedef struct packed {
    logic [POS_W-1:0] row_number;
    logic             lines_found;
    logic [POS_W-1:0] first_start;
    logic [WID_W-1:0] first_width;
    logic [POS_W-1:0] second_start;
    logic [WID_W-1:0] second_width;
    logic [POS_W-1:0] center_column;
    logic             frame_done;
  } row_res_t;

endpackage

// File: rtl/lld_cfg.sv
`timescale 1ns / 1ps

module lld_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lld_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lld_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output lld_pkg::cfg_t                    cfg_o
);

  lld_pkg::cfg_t cfg_d, cfg_q;

  // Always take a write
  assign cfg_ready_o = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lld_pkg::CFG_BRIGHT_THRESHOLD:
          cfg_d.bright_threshold = cfg_data_i[lld_pkg::PIX_W-1:0];
        lld_pkg::CFG_MIN_LINE_WIDTH:
          cfg_d.min_line_width = cfg_data_i[lld_pkg::LIM_W-1:0];
        lld_pkg::CFG_MAX_LINE_WIDTH:
          cfg_d.max_line_width = cfg_data_i[lld_pkg::LIM_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bright_threshold <= lld_pkg::BRIGHT_THRESHOLD_RST;
      cfg_q.min_line_width   <= lld_pkg::MIN_LINE_WIDTH_RST;
      cfg_q.max_line_width   <= lld_pkg::MAX_LINE_WIDTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/lld_scan.sv
`timescale 1ns / 1ps

module lld_scan #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  localparam int unsigned COL_W = $clog2(MAX_COLUMNS),
  localparam int unsigned LEN_W = $clog2(MAX_COLUMNS + 1),
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lld_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lld_pkg::PIX_W-1:0]  pixel_i,
  input  logic                       row_end_i,
  input  logic                       frame_end_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output lld_pkg::row_res_t          res_o,
  output logic [COL_W-1:0]           res_center_o,
  output logic [LEN_W-1:0]           res_row_width_o,
  output logic [ROW_W-1:0]           res_row_o
);

  localparam int unsigned CMP_W = (LEN_W > lld_pkg::LIM_W) ? LEN_W : lld_pkg::LIM_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_COLUMNS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

  // Input register
  logic                      a_vld_q;
  logic [lld_pkg::PIX_W-1:0] pix_q;
  logic                      row_end_q, frame_end_q;

  // Scan state
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             in_run_q, in_run_d;
  logic [COL_W-1:0] run_start_q, run_start_d;
  logic [LEN_W-1:0] run_len_q, run_len_d;
  logic [COL_W-1:0] s0_q, s1_q, s0_d, s1_d;
  logic [LEN_W-1:0] w0_q, w1_q, w0_d, w1_d;

  // Result register
  logic              b_vld_q;
  lld_pkg::row_res_t b_res_q;
  logic [COL_W-1:0]  b_center_q;
  logic [LEN_W-1:0]  b_row_width_q;
  logic [ROW_W-1:0]  b_row_q;

  logic             a_rdy, b_rdy, take, bright, row_done;
  logic [COL_W-1:0] cand_start;
  logic [LEN_W-1:0] cand_len;
  logic             cand_offer, in_limits, pick, replace, found;
  logic [LEN_W-1:0] pick_w;
  logic [COL_W-1:0] ns0, ns1;
  logic [LEN_W-1:0] nw0, nw1;
  logic [COL_W:0]   start_sum;
  logic [COL_W-1:0] center;

  assign b_rdy      = !b_vld_q || res_ready_i;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_stall_o = !a_rdy;
  assign take       = a_vld_q && b_rdy;

  assign bright   = pix_q > cfg_i.bright_threshold;
  assign row_done = row_end_q || frame_end_q;

  // Form the run that this pixel leaves behind or extends
  always_comb begin
    if (bright) begin
      if (!in_run_q) begin
        cand_start = col_q;
        cand_len   = LEN_W'(1);
      end else begin
        cand_start = run_start_q;
        cand_len   = (run_len_q < LEN_MAX) ? run_len_q + LEN_W'(1) : run_len_q;
      end
      cand_offer = row_done;
    end else begin
      cand_start = run_start_q;
      cand_len   = run_len_q;
      cand_offer = in_run_q;
    end
  end

  // Offer the run to the narrower slot, slot 0 on a tie
  assign in_limits = (CMP_W'(cand_len) >= CMP_W'(cfg_i.min_line_width)) &&
                     (CMP_W'(cand_len) <= CMP_W'(cfg_i.max_line_width));
  assign pick      = w0_q > w1_q;
  assign pick_w    = pick ? w1_q : w0_q;
  assign replace   = cand_offer && in_limits && (pick_w < cand_len);

  always_comb begin
    ns0 = s0_q;
    nw0 = w0_q;
    ns1 = s1_q;
    nw1 = w1_q;
    if (replace) begin
      if (pick) begin
        ns1 = cand_start;
        nw1 = cand_len;
      end else begin
        ns0 = cand_start;
        nw0 = cand_len;
      end
    end
  end

  assign found     = (nw0 != '0) && (nw1 != '0);
  assign start_sum = {1'b0, ns0} + {1'b0, ns1};
  assign center    = found ? start_sum[COL_W:1] : '0;

  // Next scan state
  always_comb begin
    run_start_d = cand_start;
    if (row_done) begin
      col_d     = '0;
      row_d     = (row_q < ROW_LAST) ? row_q + ROW_W'(1) : row_q;
      in_run_d  = 1'b0;
      run_len_d = '0;
      if (found || frame_end_q) begin
        s0_d = '0;
        s1_d = '0;
        w0_d = '0;
        w1_d = '0;
      end else begin
        s0_d = ns0;
        s1_d = ns1;
        w0_d = nw0;
        w1_d = nw1;
      end
      if (frame_end_q) begin
        row_d       = '0;
        run_start_d = '0;
      end
    end else begin
      col_d     = (col_q < COL_LAST) ? col_q + COL_W'(1) : col_q;
      row_d     = row_q;
      in_run_d  = bright;
      run_len_d = bright ? cand_len : '0;
      s0_d      = ns0;
      s1_d      = ns1;
      w0_d      = nw0;
      w1_d      = nw1;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_rdy) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      pix_q       <= pixel_i;
      row_end_q   <= row_end_i;
      frame_end_q <= frame_end_i;
    end
  end

  // Advance the scan state on each taken pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      in_run_q    <= 1'b0;
      run_start_q <= '0;
      run_len_q   <= '0;
      s0_q        <= '0;
      s1_q        <= '0;
      w0_q        <= '0;
      w1_q        <= '0;
    end else if (take) begin
      col_q       <= col_d;
      row_q       <= row_d;
      in_run_q    <= in_run_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      s0_q        <= s0_d;
      s1_q        <= s1_d;
      w0_q        <= w0_d;
      w1_q        <= w1_d;
    end
  end

  // Row result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_rdy) begin
      b_vld_q <= a_vld_q && row_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && row_done) begin
      b_res_q.row_number    <= lld_pkg::POS_W'(row_q);
      b_res_q.lines_found   <= found;
      b_res_q.first_start   <= lld_pkg::POS_W'(ns0);
      b_res_q.first_width   <= lld_pkg::WID_W'(nw0);
      b_res_q.second_start  <= lld_pkg::POS_W'(ns1);
      b_res_q.second_width  <= lld_pkg::WID_W'(nw1);
      b_res_q.center_column <= lld_pkg::POS_W'(center);
      b_res_q.frame_done    <= frame_end_q;
      b_center_q            <= center;
      b_row_width_q         <= LEN_W'(col_q) + LEN_W'(1);
      b_row_q               <= row_q;
    end
  end

  assign res_valid_o     = b_vld_q;
  assign res_o           = b_res_q;
  assign res_center_o    = b_center_q;
  assign res_row_width_o = b_row_width_q;
  assign res_row_o       = b_row_q;

endmodule

// File: rtl/lld_steer.sv
`timescale 1ns / 1ps

module lld_steer #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  localparam int unsigned COL_W = $clog2(MAX_COLUMNS),
  localparam int unsigned LEN_W = $clog2(MAX_COLUMNS + 1),
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  output logic                              res_ready_o,
  input  lld_pkg::row_res_t                 res_i,
  input  logic [COL_W-1:0]                  res_center_i,
  input  logic [LEN_W-1:0]                  res_row_width_i,
  input  logic [ROW_W-1:0]                  res_row_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lld_pkg::row_res_t                 out_res_o,
  output logic signed [lld_pkg::SUM_W-1:0]  steer_sum_o
);

  localparam int unsigned DIFF_W = COL_W + 2;
  localparam int unsigned PROD_W = DIFF_W + ROW_W + 1;
  localparam int unsigned ACC_W  = lld_pkg::SUM_W + 1;
  localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(lld_pkg::STEER_LIMIT);
  localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(lld_pkg::STEER_LIMIT);

  logic                       c_vld_q;
  lld_pkg::row_res_t          c_res_q;
  logic signed [PROD_W-1:0]   term_q;

  logic                             d_vld_q;
  lld_pkg::row_res_t                d_res_q;
  logic signed [lld_pkg::SUM_W-1:0] sum_q;
  logic signed [lld_pkg::SUM_W-1:0] acc_q, acc_d;

  logic                       c_rdy, d_rdy;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [ROW_W:0]      row_s;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [lld_pkg::SUM_W-1:0] acc_sat;

  assign d_rdy       = !d_vld_q || !out_stall_i;
  assign c_rdy       = !c_vld_q || d_rdy;
  assign res_ready_o = c_rdy;

  // Form this row's steering term
  assign diff  = $signed({1'b0, res_center_i, 1'b0}) - $signed(DIFF_W'(res_row_width_i));
  assign row_s = $signed({1'b0, res_row_i});
  assign prod  = diff * row_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (c_rdy) begin
      c_vld_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_rdy && res_valid_i) begin
      c_res_q <= res_i;
      term_q  <= res_i.lines_found ? prod : '0;
    end
  end

  // Accumulate and clamp; drop the sum at frame end
  assign acc_sum = ACC_W'(acc_q) + ACC_W'(term_q);

  always_comb begin
    if (acc_sum > LIM_POS) begin
      acc_sat = lld_pkg::STEER_LIMIT;
    end else if (acc_sum < LIM_NEG) begin
      acc_sat = -lld_pkg::STEER_LIMIT;
    end else begin
      acc_sat = acc_sum[lld_pkg::SUM_W-1:0];
    end
    acc_d = c_res_q.frame_done ? '0 : acc_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      acc_q   <= '0;
    end else if (d_rdy) begin
      d_vld_q <= c_vld_q;
      if (c_vld_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy && c_vld_q) begin
      d_res_q <= c_res_q;
      sum_q   <= acc_sat;
    end
  end

  assign out_valid_o = d_vld_q;
  assign out_res_o   = d_res_q;
  assign steer_sum_o = sum_q;

endmodule

// File: rtl/lane_line_run_detector.sv
`timescale 1ns / 1ps
// Results pass the input, row result, steering term and output registers. Throughput:
// one pixel per cycle while in_stall_o is low; the scan state (run, slots, counters)
// moves per taken pixel; steering multiply and clamped accumulate take one stage each.
// Reset (asynchronous, active low) clears counters, slots, the steering sum and all
// valid flags, and loads the threshold and width limits with their defaults.
module lane_line_run_detector #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lld_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lld_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lld_pkg::PIX_W-1:0]         pixel_i,
  input  logic                              row_end_i,
  input  logic                              frame_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lld_pkg::POS_W-1:0]         row_number_o,
  output logic                              lines_found_o,
  output logic [lld_pkg::POS_W-1:0]         first_start_o,
  output logic [lld_pkg::WID_W-1:0]         first_width_o,
  output logic [lld_pkg::POS_W-1:0]         second_start_o,
  output logic [lld_pkg::WID_W-1:0]         second_width_o,
  output logic [lld_pkg::POS_W-1:0]         center_column_o,
  output logic signed [lld_pkg::SUM_W-1:0]  steer_sum_o,
  output logic                              frame_done_o
);

  localparam int unsigned COL_W = $clog2(MAX_COLUMNS);
  localparam int unsigned LEN_W = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  lld_pkg::cfg_t     cfg;
  lld_pkg::row_res_t row_res, out_res;
  logic              res_valid, res_ready;
  logic [COL_W-1:0]  res_center;
  logic [LEN_W-1:0]  res_row_width;
  logic [ROW_W-1:0]  res_row;

  lld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lld_scan #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_i         (pixel_i),
    .row_end_i       (row_end_i),
    .frame_end_i     (frame_end_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (row_res),
    .res_center_o    (res_center),
    .res_row_width_o (res_row_width),
    .res_row_o       (res_row)
  );

  lld_steer #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_steer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_ready_o     (res_ready),
    .res_i           (row_res),
    .res_center_i    (res_center),
    .res_row_width_i (res_row_width),
    .res_row_i       (res_row),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_res_o       (out_res),
    .steer_sum_o     (steer_sum_o)
  );

  // Unpack the result item onto its ports
  assign row_number_o    = out_res.row_number;
  assign lines_found_o   = out_res.lines_found;
  assign first_start_o   = out_res.first_start;
  assign first_width_o   = out_res.first_width;
  assign second_start_o  = out_res.second_start;
  assign second_width_o  = out_res.second_width;
  assign center_column_o = out_res.center_column;
  assign frame_done_o    = out_res.frame_done;

endmodule

// File: rtl/lld_checker.sv
`timescale 1ns / 1ps

module lld_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [lld_pkg::POS_W-1:0]         row_number_o,
  input logic                              lines_found_o,
  input logic [lld_pkg::WID_W-1:0]         first_width_o,
  input logic [lld_pkg::WID_W-1:0]         second_width_o,
  input logic [lld_pkg::POS_W-1:0]         center_column_o,
  input logic signed [lld_pkg::SUM_W-1:0]  steer_sum_o
);

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(steer_sum_o) && $stable(row_number_o))
    else $error("stalled result item changed");

  // Lines are reported exactly when both slots hold a width
  a_found_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (lines_found_o == ((first_width_o != '0) && (second_width_o != '0))))
    else $error("lines_found disagrees with slot widths");

  // No centre without a pair of lines
  a_center_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lines_found_o |-> (center_column_o == '0))
    else $error("centre column set without lines");

  // Steering sum stays within its clamp
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (steer_sum_o <= lld_pkg::STEER_LIMIT) && (steer_sum_o >= -lld_pkg::STEER_LIMIT))
    else $error("steering sum outside its clamp");

endmodule

bind lane_line_run_detector lld_checker u_lld_checker (.*);

// File: test/lld_checker.sv
`timescale 1ns / 1ps

module lld_scoreboard #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [lld_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lld_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [lld_pkg::PIX_W-1:0]         pixel_i,
  input  logic                              row_end_i,
  input  logic                              frame_end_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [lld_pkg::POS_W-1:0]         row_number_i,
  input  logic                              lines_found_i,
  input  logic [lld_pkg::POS_W-1:0]         first_start_i,
  input  logic [lld_pkg::WID_W-1:0]         first_width_i,
  input  logic [lld_pkg::POS_W-1:0]         second_start_i,
  input  logic [lld_pkg::WID_W-1:0]         second_width_i,
  input  logic [lld_pkg::POS_W-1:0]         center_column_i,
  input  logic signed [lld_pkg::SUM_W-1:0]  steer_sum_i,
  input  logic                              frame_done_i,
  output int                                pending_o,
  output int                                fail_count_o,
  output int                                rows_checked_o,
  output int                                lines_rows_o
);

  typedef struct packed {
    lld_pkg::row_res_t                row;
    logic signed [lld_pkg::SUM_W-1:0] steer;
  } row_expect_t;

  // Register copies
  logic [lld_pkg::PIX_W-1:0] threshold;
  logic [lld_pkg::LIM_W-1:0] width_lo;
  logic [lld_pkg::LIM_W-1:0] width_hi;

  // Scan state mirrored from the block
  logic [lld_pkg::POS_W-1:0] col_idx;
  logic [lld_pkg::POS_W-1:0] row_idx;
  bit                        in_run;
  logic [lld_pkg::POS_W-1:0] run_start;
  logic [lld_pkg::WID_W-1:0] run_len;
  logic [lld_pkg::POS_W-1:0] slot_start [2];
  logic [lld_pkg::WID_W-1:0] slot_width [2];
  longint                    steer;

  row_expect_t expected_rows [$];

  // Offer the finished run to the narrower slot, slot 0 on a tie
  function automatic void offer_run();
    int k;
    if (run_len < width_lo || run_len > width_hi) return;
    k = (slot_width[0] > slot_width[1]) ? 1 : 0;
    if (slot_width[k] < run_len) begin
      slot_start[k] = run_start;
      slot_width[k] = run_len;
    end
  endfunction

  function automatic void clear_slots();
    slot_start[0] = '0;
    slot_start[1] = '0;
    slot_width[0] = '0;
    slot_width[1] = '0;
  endfunction

  // Advance the scan by one pixel; returns 1 when the pixel closes a row
  function automatic bit scan_pixel(input logic [lld_pkg::PIX_W-1:0] pix, input logic re,
                                    input logic fe, output row_expect_t res);
    logic   ends_row;
    bit     found;
    int     center;
    int     row_width;
    longint term;
    ends_row = re | fe;
    center   = 0;
    res      = '0;

    if (pix > threshold) begin
      if (!in_run) begin
        in_run    = 1'b1;
        run_start = col_idx;
        run_len   = lld_pkg::WID_W'(1);
      end else if (run_len < MAX_COLUMNS) begin
        run_len++;
      end
    end else if (in_run) begin
      offer_run();
      in_run  = 1'b0;
      run_len = '0;
    end

    if (!ends_row) begin
      if (col_idx < MAX_COLUMNS - 1) col_idx++;
      return 1'b0;
    end

    // A run still open at the row end includes the last pixel
    if (in_run) offer_run();
    in_run    = 1'b0;
    run_len   = '0;
    row_width = int'(col_idx) + 1;

    found = slot_width[0] != 0 && slot_width[1] != 0;
    if (found) begin
      center = (int'(slot_start[0]) + int'(slot_start[1])) >> 1;
      term   = longint'(2 * center - row_width) * longint'(row_idx);
      steer += term;
      if (steer > longint'(lld_pkg::STEER_LIMIT)) steer = longint'(lld_pkg::STEER_LIMIT);
      if (steer < -longint'(lld_pkg::STEER_LIMIT)) steer = -longint'(lld_pkg::STEER_LIMIT);
    end

    res.row.row_number    = row_idx;
    res.row.lines_found   = found;
    res.row.first_start   = slot_start[0];
    res.row.first_width   = slot_width[0];
    res.row.second_start  = slot_start[1];
    res.row.second_width  = slot_width[1];
    res.row.center_column = lld_pkg::POS_W'(center);
    res.row.frame_done    = fe;
    res.steer             = steer[lld_pkg::SUM_W-1:0];

    if (found) clear_slots();
    col_idx = '0;
    if (row_idx < MAX_ROWS - 1) row_idx++;

    // Frame end returns the whole scan to its reset state
    if (fe) begin
      steer     = 0;
      row_idx   = '0;
      run_start = '0;
      clear_slots();
    end
    return 1'b1;
  endfunction

  // Compare accepted rows, track register writes and predict accepted pixels
  always @(posedge clk_i or negedge rst_ni) begin : track
    row_expect_t want;
    row_expect_t got;
    if (!rst_ni) begin
      threshold      = lld_pkg::BRIGHT_THRESHOLD_RST;
      width_lo       = lld_pkg::MIN_LINE_WIDTH_RST;
      width_hi       = lld_pkg::MAX_LINE_WIDTH_RST;
      col_idx        = '0;
      row_idx        = '0;
      in_run         = 1'b0;
      run_start      = '0;
      run_len        = '0;
      steer          = 0;
      clear_slots();
      expected_rows.delete();
      pending_o      = 0;
      fail_count_o   = 0;
      rows_checked_o = 0;
      lines_rows_o   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rows.size() == 0) begin
          $error("row result for row %0d arrived with no row pending", row_number_i);
          fail_count_o++;
        end else begin
          want = expected_rows.pop_front();
          got.row.row_number    = row_number_i;
          got.row.lines_found   = lines_found_i;
          got.row.first_start   = first_start_i;
          got.row.first_width   = first_width_i;
          got.row.second_start  = second_start_i;
          got.row.second_width  = second_width_i;
          got.row.center_column = center_column_i;
          got.row.frame_done    = frame_done_i;
          got.steer             = steer_sum_i;
          if (got.row.row_number !== want.row.row_number) begin
            $error("row_number: expected %0d, got %0d", want.row.row_number,
                   got.row.row_number);
            fail_count_o++;
          end
          if (got.row.lines_found !== want.row.lines_found) begin
            $error("lines_found: expected %0d, got %0d", want.row.lines_found,
                   got.row.lines_found);
            fail_count_o++;
          end
          if (got.row.first_start !== want.row.first_start) begin
            $error("first_start: expected %0d, got %0d", want.row.first_start,
                   got.row.first_start);
            fail_count_o++;
          end
          if (got.row.first_width !== want.row.first_width) begin
            $error("first_width: expected %0d, got %0d", want.row.first_width,
                   got.row.first_width);
            fail_count_o++;
          end
          if (got.row.second_start !== want.row.second_start) begin
            $error("second_start: expected %0d, got %0d", want.row.second_start,
                   got.row.second_start);
            fail_count_o++;
          end
          if (got.row.second_width !== want.row.second_width) begin
            $error("second_width: expected %0d, got %0d", want.row.second_width,
                   got.row.second_width);
            fail_count_o++;
          end
          if (got.row.center_column !== want.row.center_column) begin
            $error("center_column: expected %0d, got %0d", want.row.center_column,
                   got.row.center_column);
            fail_count_o++;
          end
          if (got.steer !== want.steer) begin
            $error("steer_sum: expected %0d, got %0d", want.steer, got.steer);
            fail_count_o++;
          end
          if (got.row.frame_done !== want.row.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.row.frame_done,
                   got.row.frame_done);
            fail_count_o++;
          end
          rows_checked_o++;
          if (want.row.lines_found) lines_rows_o++;
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          lld_pkg::CFG_BRIGHT_THRESHOLD: threshold = cfg_data_i[lld_pkg::PIX_W-1:0];
          lld_pkg::CFG_MIN_LINE_WIDTH:   width_lo  = cfg_data_i[lld_pkg::LIM_W-1:0];
          lld_pkg::CFG_MAX_LINE_WIDTH:   width_hi  = cfg_data_i[lld_pkg::LIM_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (scan_pixel(pixel_i, row_end_i, frame_end_i, want)) expected_rows.push_back(want);
      end

      pending_o = expected_rows.size();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 4000;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [lld_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [lld_pkg::CFG_DATA_W-1:0]    cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [lld_pkg::PIX_W-1:0]         pixel_i;
  logic                              row_end_i;
  logic                              frame_end_i;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [lld_pkg::POS_W-1:0]         row_number_o;
  logic                              lines_found_o;
  logic [lld_pkg::POS_W-1:0]         first_start_o;
  logic [lld_pkg::WID_W-1:0]         first_width_o;
  logic [lld_pkg::POS_W-1:0]         second_start_o;
  logic [lld_pkg::WID_W-1:0]         second_width_o;
  logic [lld_pkg::POS_W-1:0]         center_column_o;
  logic signed [lld_pkg::SUM_W-1:0]  steer_sum_o;
  logic                              frame_done_o;

  int pending;
  int fail_count;
  int rows_checked;
  int lines_rows;
  int pixels_sent;
  int idle_cycles;
  bit quiet;
  logic [lld_pkg::PIX_W-1:0] cur_thr;
  int cur_max;

  lane_line_run_detector dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .pixel_i, .row_end_i, .frame_end_i,
    .out_valid_o, .out_stall_i, .row_number_o, .lines_found_o,
    .first_start_o, .first_width_o, .second_start_o, .second_width_o,
    .center_column_o, .steer_sum_o, .frame_done_o
  );

  lld_scoreboard u_sb (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .pixel_i, .row_end_i, .frame_end_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .row_number_i(row_number_o), .lines_found_i(lines_found_o),
    .first_start_i(first_start_o), .first_width_i(first_width_o),
    .second_start_i(second_start_o), .second_width_i(second_width_o),
    .center_column_i(center_column_o), .steer_sum_i(steer_sum_o),
    .frame_done_i(frame_done_o),
    .pending_o(pending), .fail_count_o(fail_count),
    .rows_checked_o(rows_checked), .lines_rows_o(lines_rows)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stall the result side at random, except in quiet stretches
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 11);
  end

  // Abort when no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one pixel, with random gaps ahead of it, and hold until taken
  task automatic send_pixel(input logic [lld_pkg::PIX_W-1:0] pix, input logic re,
                            input logic fe);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    pixel_i     = pix;
    row_end_i   = re;
    frame_end_i = fe;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
  endtask

  // Hold the input until every pending row is out and the pipeline is empty
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lld_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lld_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Load all three registers; the threshold carries junk in its unused top bits
  task automatic set_limits(input logic [lld_pkg::PIX_W-1:0] thr, input int lo, input int hi);
    write_reg(lld_pkg::CFG_BRIGHT_THRESHOLD, {3'($urandom_range(7)), thr});
    write_reg(lld_pkg::CFG_MIN_LINE_WIDTH, lld_pkg::CFG_DATA_W'(lo));
    write_reg(lld_pkg::CFG_MAX_LINE_WIDTH, lld_pkg::CFG_DATA_W'(hi));
    cur_thr = thr;
    cur_max = hi;
  endtask

  function automatic logic [lld_pkg::PIX_W-1:0] level(input bit bright);
    if (bright && cur_thr != 8'd255) return 8'($urandom_range(255, int'(cur_thr) + 1));
    return 8'($urandom_range(int'(cur_thr), 0));
  endfunction

  // Alternate bright runs and dark gaps, sprinkled with noise
  task automatic send_row(input int len, input bit last);
    int col;
    int seg;
    bit bright;
    bit tail;
    logic [lld_pkg::PIX_W-1:0] pix;
    col    = 0;
    bright = 1'($urandom_range(1));
    while (col < len) begin
      seg = bright ? $urandom_range(1, (cur_max < 38) ? cur_max + 2 : 40)
                   : $urandom_range(1, 4);
      for (int k = 0; k < seg && col < len; k++) begin
        pix  = ($urandom_range(15) == 0) ? 8'($urandom) : level(bright);
        tail = (col == len - 1);
        if (col == len / 2 && $urandom_range(39) == 0) settle();
        send_pixel(pix, tail && (!last || $urandom_range(1)), tail && last);
        col++;
      end
      bright = !bright;
    end
  endtask

  // Send whole frames of small rows until the pixel quota is used
  task automatic send_frames(input int quota);
    int stop;
    int rows;
    stop = pixels_sent + quota;
    while (pixels_sent < stop) begin
      rows = $urandom_range(1, 8);
      for (int r = 0; r < rows; r++) send_row($urandom_range(1, 40), r == rows - 1);
    end
  endtask

  initial begin
    int lo;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = lld_pkg::CFG_BRIGHT_THRESHOLD;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    row_end_i   = 1'b0;
    frame_end_i = 1'b0;
    quiet       = 1'b0;
    pixels_sent = 0;
    idle_cycles = 0;
    cur_thr     = lld_pkg::BRIGHT_THRESHOLD_RST;
    cur_max     = int'(lld_pkg::MAX_LINE_WIDTH_RST);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset limits: three runs where the last ties and is dropped
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd0,   1'b0, 1'b0);
    send_pixel(8'd200, 1'b0, 1'b0);
    send_pixel(8'd200, 1'b0, 1'b0);
    send_pixel(8'd200, 1'b0, 1'b0);
    send_pixel(8'd50,  1'b0, 1'b0);
    send_pixel(8'd101, 1'b0, 1'b0);
    send_pixel(8'd101, 1'b1, 1'b0);
    // One slot filled, carried over; pause mid-row until the pipe drains
    send_pixel(8'd100, 1'b0, 1'b0);
    send_pixel(8'd150, 1'b0, 1'b0);
    settle();
    send_pixel(8'd150, 1'b0, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b0);
    // Frame end alone closes the row; the open run fills the second slot
    send_pixel(8'd0,   1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b1);
    // One-pixel frame, and a narrow run under the minimum
    send_pixel(8'd255, 1'b1, 1'b1);
    send_pixel(8'd101, 1'b0, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b1);
    settle();

    // Register extremes, then crossed limits
    set_limits(8'd0, 1, 1024);
    send_frames(40);
    settle();
    set_limits(8'd255, 1024, 1024);
    send_frames(40);
    settle();
    set_limits(8'd128, 5, 3);
    send_frames(40);
    settle();

    // Frame without gaps: an over-long first row saturates column and run length
    set_limits(8'($urandom_range(60, 200)), 1, 1024);
    quiet = 1'b1;
    repeat (10) send_pixel(level(1'b1), 1'b0, 1'b0);
    repeat (3) send_pixel(level(1'b0), 1'b0, 1'b0);
    repeat (1029) send_pixel(level(1'b1), 1'b0, 1'b0);
    send_pixel(level(1'b1), 1'b1, 1'b0);
    for (int r = 0; r < 8; r++) begin
      send_pixel(8'($urandom), (r != 7) ? 1'b1 : 1'($urandom_range(1)), r == 7);
    end
    settle();
    quiet = 1'b0;

    // Random settings
    repeat (3) begin
      lo = $urandom_range(1, 4);
      set_limits(8'($urandom_range(30, 220)), lo, $urandom_range(lo, 30));
      send_frames(40);
      settle();
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d pixels; checked %0d rows, %0d of them with both lines found.",
             pixels_sent, rows_checked, lines_rows);
    $display("Ran reset limits, width extremes, crossed limits, an over-long row and random limits.");
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
